// ===== hdl/itrd_pkg.sv =====
// Package for the integer-to-radix-digits unit: widths, limits, back-end state codes
// and the helpers for clamping the radix and mapping a digit to its character.
// No dependencies.
`default_nettype none

package itrd_pkg;

    localparam int ITRD_VALUE_BITS  = 64;  // default magnitude width
    localparam int ITRD_IN_BITS     = 64;  // width of the value port
    localparam int ITRD_RADIX_BITS  = 6;
    localparam int ITRD_CHAR_BITS   = 7;
    localparam int ITRD_CHUNK_BITS  = 8;   // dividend bits consumed per division cycle
    localparam int ITRD_QUEUE_DEPTH = 2;   // power of two

    typedef logic [ITRD_RADIX_BITS-1:0] radix_t;
    typedef logic [ITRD_CHAR_BITS-1:0]  char_t;

    localparam radix_t RADIX_MIN   = 6'd2;
    localparam radix_t RADIX_MAX   = 6'd36;
    localparam radix_t RADIX_RESET = 6'd10;

    localparam char_t CHAR_ZERO    = 7'd48;  // '0'
    localparam char_t CHAR_ALPHA   = 7'd87;  // 'a' minus ten
    localparam char_t DECIMAL_TOP  = 7'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_OUT
    } back_state_t;

    function automatic radix_t clamp_radix(input radix_t r);
        radix_t c;
        c = r;
        if (r < RADIX_MIN) c = RADIX_MIN;
        if (r > RADIX_MAX) c = RADIX_MAX;
        return c;
    endfunction

    function automatic char_t digit_to_char(input radix_t d);
        char_t e;
        e = {1'b0, d};
        if (e < DECIMAL_TOP) return CHAR_ZERO + e;
        return CHAR_ALPHA + e;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/itrd_fifo.sv =====
// Short queue between front and back end of the integer-to-radix-digits unit.
// Uses itrd_pkg for its depth.
`default_nettype none

module itrd_fifo import itrd_pkg::*; #(
    parameter int DATA_BITS = ITRD_VALUE_BITS + 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire logic [DATA_BITS-1:0] push_data,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      pop_valid,
    output logic [DATA_BITS-1:0]      pop_data
);

    localparam int DEPTH = ITRD_QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== hdl/itrd_front.sv =====
// Front end of the integer-to-radix-digits unit: takes input beats, classifies sign
// and forms the magnitude, and pushes {negative, magnitude} into the queue. Uses itrd_pkg.
`default_nettype none

module itrd_front import itrd_pkg::*; #(
    parameter int VALUE_BITS = ITRD_VALUE_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [ITRD_IN_BITS-1:0] s_value,
    input  wire logic                    s_req_type,
    output logic                         q_push,
    output logic [VALUE_BITS:0]          q_data,
    input  wire logic                    q_full
);

    logic                  hold_valid_reg, hold_valid_next;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  signed_reg;
    logic                  negative;
    logic [VALUE_BITS-1:0] magnitude;
    logic                  take;

    assign q_push  = hold_valid_reg && !q_full;
    assign s_ready = !hold_valid_reg || q_push;
    assign take    = s_valid && s_ready;

    // most negative value negates to itself, which is the right unsigned magnitude
    assign negative  = signed_reg && val_reg[VALUE_BITS-1];
    assign magnitude = negative ? (~val_reg + VALUE_BITS'(1)) : val_reg;
    assign q_data    = {negative, magnitude};

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (take)        hold_valid_next = 1'b1;
        else if (q_push) hold_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            val_reg    <= s_value[VALUE_BITS-1:0];
            signed_reg <= s_req_type;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/itrd_back.sv =====
// Back end of the integer-to-radix-digits unit: byte-serial long division by the radix,
// digit memory, and most-significant-first emission through an output register. Uses itrd_pkg.
`default_nettype none

module itrd_back import itrd_pkg::*; #(
    parameter int VALUE_BITS = ITRD_VALUE_BITS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire radix_t              radix,
    input  wire logic                q_valid,
    input  wire logic [VALUE_BITS:0] q_data,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output char_t                    m_digit_char,
    output logic                     m_minus_before,
    output logic                     m_last
);

    localparam int CHUNK_BITS = ITRD_CHUNK_BITS;
    localparam int RADIX_BITS = ITRD_RADIX_BITS;
    localparam int NUM_CHUNKS = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PAD_BITS   = NUM_CHUNKS * CHUNK_BITS;
    localparam int CIDX_W     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int ADDR_W     = $clog2(VALUE_BITS);

    back_state_t           state_reg, state_next;
    logic [PAD_BITS-1:0]   quo_reg, quo_new, q_mag_pad;
    radix_t                rem_reg, rem_out;
    logic [CIDX_W-1:0]     chunk_reg;
    logic                  neg_reg;
    logic                  first_reg;
    logic [ADDR_W-1:0]     wr_idx_reg;
    logic [ADDR_W-1:0]     rd_idx_reg;
    radix_t                mem [VALUE_BITS];
    radix_t                mem_rdata_reg;
    logic                  m_valid_reg, m_valid_next;
    char_t                 m_char_reg;
    logic                  m_minus_reg;
    logic                  m_last_reg;

    logic [CHUNK_BITS-1:0] chunk_in, chunk_q;
    logic [RADIX_BITS:0]   part;
    logic                  digit_done, quo_zero, out_free;
    logic                  take_item, mem_we, load_out;

    // highest byte of x that holds a set bit; zero when x is zero
    function automatic logic [CIDX_W-1:0] top_chunk(input logic [PAD_BITS-1:0] x);
        logic [CIDX_W-1:0] h;
        h = '0;
        for (int i = 0; i < NUM_CHUNKS; i++) begin
            if (|x[i*CHUNK_BITS +: CHUNK_BITS]) h = CIDX_W'(i);
        end
        return h;
    endfunction

    assign q_mag_pad = PAD_BITS'(q_data[VALUE_BITS-1:0]);

    // one byte of restoring division: remainder stays below the radix
    always_comb begin
        chunk_in = quo_reg[chunk_reg*CHUNK_BITS +: CHUNK_BITS];
        part     = {1'b0, rem_reg};
        chunk_q  = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
            part = {part[RADIX_BITS-1:0], chunk_in[i]};
            if (part >= {1'b0, radix}) begin
                part       = part - {1'b0, radix};
                chunk_q[i] = 1'b1;
            end
        end
        rem_out = part[RADIX_BITS-1:0];
    end

    always_comb begin
        quo_new = quo_reg;
        quo_new[chunk_reg*CHUNK_BITS +: CHUNK_BITS] = chunk_q;
    end

    assign digit_done = (chunk_reg == '0);
    assign quo_zero   = (quo_new == '0);
    assign out_free   = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (digit_done && quo_zero) state_next = ST_RD;
            end
            ST_RD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) state_next = (rd_idx_reg == '0) ? ST_IDLE : ST_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        take_item = 1'b0;
        mem_we    = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                take_item = q_valid;
            end
            ST_DIV: begin
                mem_we = digit_done;
            end
            ST_OUT: begin
                load_out = out_free;
            end
            default: begin
                take_item = 1'b0;
            end
        endcase
    end

    assign q_pop = take_item;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out)     m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // division datapath
    always_ff @(posedge aclk) begin
        if (take_item) begin
            quo_reg    <= q_mag_pad;
            neg_reg    <= q_data[VALUE_BITS];
            wr_idx_reg <= '0;
            rem_reg    <= '0;
            chunk_reg  <= top_chunk(q_mag_pad);
        end else if (state_reg == ST_DIV) begin
            quo_reg <= quo_new;
            if (digit_done) begin
                rem_reg    <= '0;
                chunk_reg  <= top_chunk(quo_new);
                wr_idx_reg <= wr_idx_reg + 1'b1;
                if (quo_zero) begin
                    rd_idx_reg <= wr_idx_reg;
                    first_reg  <= 1'b1;
                end
            end else begin
                rem_reg   <= rem_out;
                chunk_reg <= chunk_reg - 1'b1;
            end
        end else if (load_out) begin
            rd_idx_reg <= rd_idx_reg - 1'b1;
            first_reg  <= 1'b0;
        end
    end

    // digit memory, least significant digit at address zero
    always_ff @(posedge aclk) begin
        if (mem_we) mem[wr_idx_reg] <= rem_out;
        mem_rdata_reg <= mem[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_char_reg  <= digit_to_char(mem_rdata_reg);
            m_minus_reg <= first_reg && neg_reg;
            m_last_reg  <= (rd_idx_reg == '0);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_digit_char   = m_char_reg;
    assign m_minus_before = m_minus_reg;
    assign m_last         = m_last_reg;

endmodule

`default_nettype wire

// ===== hdl/integer_to_radix_digits_unit.sv =====
// Top level of the integer-to-radix-digits unit: radix register, front end, queue, back end.
// Depends on itrd_pkg, itrd_front, itrd_fifo and itrd_back.
`default_nettype none

// Converts one integer per input beat into its digits in radix 2..36, most significant
// first, one output beat per digit ('0'-'9', then 'a'-'z'). Only the low VALUE_BITS bits
// of s_value are used; with s_req_type high they are read as two's complement, the
// magnitude is converted, and m_minus_before is set on the first digit of a negative
// value. m_last marks the final digit; zero gives the single digit '0'. The radix is
// written over the cfg_ channel (reset 10; below 2 acts as 2, above 36 acts as 36) and
// must only change while the unit is idle. The front end registers and
// classifies a beat and queues it (two entries), so input beats are taken while the
// back end is busy. The back end divides the running quotient by the radix one byte
// per cycle, starting at its highest nonzero byte and working down to byte zero for
// each digit; once the quotient reaches zero the digits are read back from the digit
// memory one per output beat, each waiting for the output register to be free. The
// last digit sits in the output register while the next item is already divided.
module integer_to_radix_digits_unit import itrd_pkg::*; #(
    parameter int VALUE_BITS = ITRD_VALUE_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire radix_t                  cfg_radix,
    // input channel
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [ITRD_IN_BITS-1:0] s_value,
    input  wire logic                    s_req_type,
    // result channel
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output char_t                        m_digit_char,
    output logic                         m_minus_before,
    output logic                         m_last
);

    radix_t                radix_reg;
    radix_t                radix_eff;
    logic                  q_push, q_full, q_pop, q_valid;
    logic [VALUE_BITS:0]   q_in_data, q_out_data;

    // radix register, always ready for a beat
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            radix_reg <= cfg_radix;
        end
    end

    assign radix_eff = clamp_radix(radix_reg);

    itrd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_req_type (s_req_type),
        .q_push     (q_push),
        .q_data     (q_in_data),
        .q_full     (q_full)
    );

    itrd_fifo #(
        .DATA_BITS (VALUE_BITS + 1)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_out_data)
    );

    itrd_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .radix          (radix_eff),
        .q_valid        (q_valid),
        .q_data         (q_out_data),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digit_char   (m_digit_char),
        .m_minus_before (m_minus_before),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

// ===== sim/tb_integer_to_radix_digits_unit.sv =====
// Testbench for integer_to_radix_digits_unit: directed and random numbers over many radix
// settings, checked digit by digit against a predictor. Depends on itrd_pkg and the unit.
`default_nettype none

module tb_integer_to_radix_digits_unit;
    import itrd_pkg::*;

    localparam int          VB         = ITRD_VALUE_BITS;
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VB);
    localparam logic [63:0] ALL_ONES   = {64{1'b1}};
    localparam logic [63:0] MOST_NEG   = 64'h1 << (VB - 1);
    localparam logic        AS_UNSIGNED = 1'b0;
    localparam logic        AS_SIGNED   = 1'b1;

    typedef struct packed {
        char_t ch;
        logic  minus;
        logic  last;
    } digit_beat_t;

    typedef struct {
        logic [63:0] value;
        logic        req_type;
        logic        drain_first;   // hold this beat back until every digit is out
    } number_beat_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    radix_t                  cfg_radix = RADIX_RESET;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [ITRD_IN_BITS-1:0] s_value = '0;
    logic                    s_req_type = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    char_t                   m_digit_char;
    logic                    m_minus_before;
    logic                    m_last;

    integer_to_radix_digits_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_radix      (cfg_radix),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_req_type     (s_req_type),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digit_char   (m_digit_char),
        .m_minus_before (m_minus_before),
        .m_last         (m_last)
    );

    number_beat_t numbers_pending[$];
    digit_beat_t  digits_due[$];
    radix_t       radix_now = RADIX_RESET;   // predictor's copy of the register
    radix_t       radix_req = RADIX_RESET;
    int           cfg_issued = 0;
    int           cfg_written = 0;
    int           numbers_queued = 0;
    int           numbers_taken = 0;
    int           digits_checked = 0;
    int           negatives_seen = 0;
    int           mismatches = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    logic         s_fire = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Expected digit beats for one number at the current radix, most significant first.
    function automatic void expand_digits(input logic [63:0] raw, input logic as_signed);
        logic [63:0] mag;
        logic [63:0] base;
        logic [5:0]  vals[$];
        logic        neg;
        digit_beat_t b;
        int          k;
        mag  = raw & VALUE_MASK;
        base = 64'(radix_now);
        if (radix_now < RADIX_MIN) base = 64'(RADIX_MIN);
        if (radix_now > RADIX_MAX) base = 64'(RADIX_MAX);
        neg = as_signed && mag[VB-1];
        if (neg) begin
            mag = (~mag + 64'd1) & VALUE_MASK;
            negatives_seen++;
        end
        do begin
            vals.push_back(6'(mag % base));
            mag = mag / base;
        end while (mag != 0);
        for (k = vals.size() - 1; k >= 0; k--) begin
            b.ch    = (vals[k] < 6'd10) ? CHAR_ZERO + char_t'(vals[k])
                                        : CHAR_ALPHA + char_t'(vals[k]);
            b.minus = (k == vals.size() - 1) ? neg : 1'b0;
            b.last  = (k == 0);
            digits_due.push_back(b);
        end
    endfunction

    // Driver: everything changes on the falling edge.
    always @(negedge aclk) begin
        number_beat_t nxt;
        if (aresetn) begin
            cfg_valid <= (cfg_issued != cfg_written);
            cfg_radix <= radix_req;
            m_ready   <= ($urandom_range(0, 99) >= stall_pct);
            if (!s_valid || s_fire) begin
                if (numbers_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                    (!numbers_pending[0].drain_first || digits_due.size() == 0)) begin
                    nxt = numbers_pending.pop_front();
                    s_value    <= nxt.value;
                    s_req_type <= nxt.req_type;
                    s_valid    <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: beats are sampled on the rising edge.
    always @(posedge aclk) begin
        digit_beat_t exp_b;
        s_fire = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                radix_now = cfg_radix;
                cfg_written++;
            end
            if (s_valid && s_ready) begin
                s_fire = 1'b1;
                numbers_taken++;
                expand_digits(s_value, s_req_type);
            end
            if (m_valid && m_ready) begin
                if (digits_due.size() == 0) begin
                    $error("unexpected digit beat: char %0d minus %0b last %0b",
                           m_digit_char, m_minus_before, m_last);
                    mismatches++;
                end else begin
                    exp_b = digits_due.pop_front();
                    digits_checked++;
                    if (m_digit_char !== exp_b.ch) begin
                        $error("digit_char: expected %0d actual %0d", exp_b.ch, m_digit_char);
                        mismatches++;
                    end
                    if (m_minus_before !== exp_b.minus) begin
                        $error("minus_before: expected %0b actual %0b",
                               exp_b.minus, m_minus_before);
                        mismatches++;
                    end
                    if (m_last !== exp_b.last) begin
                        $error("last: expected %0b actual %0b", exp_b.last, m_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic queue_number(input logic [63:0] v, input logic t, input logic hold);
        number_beat_t n;
        n.value       = v;
        n.req_type    = t;
        n.drain_first = hold;
        numbers_pending.push_back(n);
        numbers_queued++;
    endtask

    task automatic wait_drained();
        while (numbers_taken != numbers_queued || digits_due.size() != 0 ||
               cfg_written != cfg_issued)
            @(negedge aclk);
    endtask

    // Radix writes happen only with the unit idle.
    task automatic write_radix(input radix_t r);
        wait_drained();
        radix_req = r;
        cfg_issued++;
        while (cfg_written != cfg_issued) @(negedge aclk);
    endtask

    task automatic random_phase(input radix_t r, input int mode, input int count);
        logic [63:0] v;
        logic [63:0] p;
        logic [63:0] base;
        int          i;
        int          k;
        write_radix(r);
        idle_pct  = (mode == 1) ? 76 : (mode == 3) ? 22 : 0;
        stall_pct = (mode == 2) ? 76 : (mode == 3) ? 22 : 0;
        base = 64'(r);
        if (r < RADIX_MIN) base = 64'(RADIX_MIN);
        if (r > RADIX_MAX) base = 64'(RADIX_MAX);
        for (i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: v = {$urandom, $urandom};
                3:       v = 64'($urandom_range(0, 1000));
                4: begin
                    // near a power of the radix, where the digit count steps
                    p = 64'd1;
                    k = $urandom_range(1, 64);
                    while (k > 0 && p <= ALL_ONES / base) begin
                        p = p * base;
                        k--;
                    end
                    v = p + 64'($urandom_range(0, 2)) - 64'd1;
                end
                5:       v = -64'($urandom_range(1, 1000));
                6:       v = 64'h1 << $urandom_range(0, 63);
                7:       v = ALL_ONES >> $urandom_range(0, 63);
                8:       v = {32'h0, $urandom};
                default: v = ($urandom_range(0, 1) != 0) ? MOST_NEG : ALL_ONES;
            endcase
            queue_number(v, 1'($urandom_range(0, 1)),
                         (i == count / 2) || ($urandom_range(0, 24) == 0));
        end
        wait_drained();
    endtask

    initial begin
        radix_t random_radix[$];
        int     ph;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset radix of ten first, no register write yet.
        queue_number(64'd0, AS_UNSIGNED, 1'b0);
        queue_number(64'd0, AS_SIGNED, 1'b0);
        queue_number(64'd1, AS_UNSIGNED, 1'b0);
        queue_number(64'd9, AS_UNSIGNED, 1'b0);
        queue_number(64'd10, AS_SIGNED, 1'b0);
        queue_number(ALL_ONES, AS_UNSIGNED, 1'b0);
        queue_number(ALL_ONES, AS_SIGNED, 1'b0);
        queue_number(MOST_NEG, AS_SIGNED, 1'b0);
        queue_number(MOST_NEG, AS_UNSIGNED, 1'b0);
        queue_number(MOST_NEG - 64'd1, AS_SIGNED, 1'b0);
        queue_number(-64'd10, AS_SIGNED, 1'b1);
        queue_number(64'hAAAA_5555_F0F0_0F0F, AS_SIGNED, 1'b0);
        // Lowest radix: longest digit strings.
        write_radix(RADIX_MIN);
        queue_number(MOST_NEG, AS_SIGNED, 1'b0);
        queue_number(ALL_ONES, AS_UNSIGNED, 1'b0);
        queue_number(64'd0, AS_UNSIGNED, 1'b0);
        queue_number(64'd1, AS_SIGNED, 1'b0);
        queue_number(64'h5555_5555_5555_5555, AS_UNSIGNED, 1'b0);
        // Highest radix: letters up to 'z'.
        write_radix(RADIX_MAX);
        queue_number(64'd35, AS_UNSIGNED, 1'b0);
        queue_number(64'd36, AS_UNSIGNED, 1'b0);
        queue_number(-64'd35, AS_SIGNED, 1'b0);
        queue_number(ALL_ONES, AS_UNSIGNED, 1'b0);
        queue_number(MOST_NEG, AS_SIGNED, 1'b0);
        queue_number(64'd1295, AS_SIGNED, 1'b0);
        wait_drained();

        // Random phases: saturating radix values included, idling mode rotates.
        random_radix = '{6'd16, 6'd0, RADIX_MAX, 6'd1, RADIX_MIN, 6'd37, 6'd63, 6'd7,
                         radix_t'($urandom_range(0, 63)), radix_t'($urandom_range(2, 36))};
        for (ph = 0; ph < random_radix.size(); ph++)
            random_phase(random_radix[ph], ph % 4, 31);

        wait_drained();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (300) @(negedge aclk);
        $display("covered %0d numbers (%0d negative), %0d digit beats checked",
                 numbers_taken, negatives_seen, digits_checked);
        $display("over %0d radix writes with four idling mixes, %0d mismatches",
                 cfg_written, mismatches);
        if (mismatches == 0 && digits_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout: %0d numbers taken, %0d digits still due",
                 numbers_taken, digits_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== integer_to_radix_digits_unit.f =====
hdl/itrd_pkg.sv
hdl/itrd_fifo.sv
hdl/itrd_front.sv
hdl/itrd_back.sv
hdl/integer_to_radix_digits_unit.sv
sim/tb_integer_to_radix_digits_unit.sv
